// File: hw/rtl/osta_pkg.sv
// ----------------------------------------------------------------------------
// osta_pkg
// Shared types and constants for the owner slot table allocator.
// ----------------------------------------------------------------------------
package osta_pkg;

    localparam int OWNER_IN_W = 64;
    localparam int SLOT_IDX_W = 9;

    localparam logic [SLOT_IDX_W-1:0] NO_SLOT = {SLOT_IDX_W{1'b1}};

    // request kinds
    localparam logic CMD_FIND    = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // request region bit patterns (signed 2-bit field)
    localparam logic [1:0] REQ_OVERWORLD = 2'b00;
    localparam logic [1:0] REQ_END       = 2'b01;
    localparam logic [1:0] REQ_INVALID   = 2'b10;
    localparam logic [1:0] REQ_NETHER    = 2'b11;

    // stored region codes
    localparam logic [1:0] RGN_OVERWORLD = 2'd0;
    localparam logic [1:0] RGN_NETHER    = 2'd1;
    localparam logic [1:0] RGN_END       = 2'd2;
    localparam logic [1:0] RGN_ALIAS_OW  = 2'd3;

    typedef struct packed {
        logic clr;
        logic load;
        logic scan;
        logic fin;
    } t_ctrl_cmd;

    typedef struct packed {
        logic reject;
        logic clr_last;
        logic scan_end;
    } t_dp_status;

endpackage

// File: hw/rtl/osta_ctrl.sv
// ----------------------------------------------------------------------------
// osta_ctrl
// Sequencer: clear sweep after reset, request load, table scan, finish.
// ----------------------------------------------------------------------------
module osta_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  osta_pkg::t_dp_status i_status,
    output osta_pkg::t_ctrl_cmd  o_cmd,
    output logic                 busy
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.reject ? ST_FIN : ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_end) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    assign busy = (r_state != ST_IDLE);

endmodule

// File: hw/rtl/osta_dpath.sv
// ----------------------------------------------------------------------------
// osta_dpath
// Slot memories, scan address and read pipeline, match and free tracking,
// write-back and result register.
// ----------------------------------------------------------------------------
module osta_dpath #(
    parameter int TABLE_DEPTH = 256,
    parameter int OWNER_BITS  = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  osta_pkg::t_ctrl_cmd                 i_cmd,
    output osta_pkg::t_dp_status                o_status,
    input  logic                                i_req_cmd,
    input  logic [osta_pkg::OWNER_IN_W-1:0]     i_owner_id,
    input  logic signed [1:0]                   i_region,
    output logic                                o_done,
    output logic signed [osta_pkg::SLOT_IDX_W-1:0] o_slot_index,
    output logic                                o_was_present,
    output logic                                o_was_claimed,
    output logic                                o_was_released
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

    logic [OWNER_BITS-1:0] r_mem_owner [TABLE_DEPTH];
    logic [1:0]            r_mem_rgn   [TABLE_DEPTH];

    logic [OWNER_BITS-1:0] r_owner;
    logic [1:0]            r_want;
    logic                  r_rel;
    logic                  r_reject;

    logic [IW-1:0]         r_clr_idx;
    logic [IW-1:0]         r_raddr;
    logic                  r_issue_all;
    logic                  r_rd_vld;
    logic [IW-1:0]         r_rd_idx;
    logic [OWNER_BITS-1:0] r_rd_owner;
    logic [1:0]            r_rd_rgn;

    logic                  r_hit;
    logic [IW-1:0]         r_hit_idx;
    logic                  r_have_free;
    logic [IW-1:0]         r_free_idx;

    logic                  r_done;
    logic [osta_pkg::SLOT_IDX_W-1:0] r_slot;
    logic                  r_pres;
    logic                  r_claim;
    logic                  r_relsd;

    logic [OWNER_BITS-1:0] in_owner;
    logic [1:0]            in_want;
    logic                  in_bad_rgn;
    logic                  rd_en;
    logic                  eval;
    logic                  owner_eq;
    logic [1:0]            rd_canon;
    logic                  match;
    logic                  we;
    logic [IW-1:0]         waddr;
    logic [OWNER_BITS-1:0] wowner;
    logic [1:0]            wrgn;
    logic                  do_claim;
    logic                  do_free;
    logic [IW+osta_pkg::SLOT_IDX_W-1:0] hit_ext;
    logic [IW+osta_pkg::SLOT_IDX_W-1:0] free_ext;

    assign in_owner = i_owner_id[OWNER_BITS-1:0];

    always_comb begin
        in_bad_rgn = 1'b0;
        case (i_region)
            osta_pkg::REQ_OVERWORLD: in_want = osta_pkg::RGN_OVERWORLD;
            osta_pkg::REQ_END:       in_want = osta_pkg::RGN_END;
            osta_pkg::REQ_NETHER:    in_want = osta_pkg::RGN_NETHER;
            default: begin
                in_want    = osta_pkg::RGN_OVERWORLD;
                in_bad_rgn = 1'b1;
            end
        endcase
    end

    assign o_status.reject   = (in_owner == '0) ||
                               ((i_req_cmd == osta_pkg::CMD_FIND) && in_bad_rgn);
    assign o_status.clr_last = (r_clr_idx == LAST_IDX);

    // scan compare on registered read data
    assign rd_en    = i_cmd.scan && !r_issue_all;
    assign eval     = i_cmd.scan && r_rd_vld;
    assign owner_eq = (r_rd_owner == r_owner);
    assign rd_canon = (r_rd_rgn == osta_pkg::RGN_ALIAS_OW) ? osta_pkg::RGN_OVERWORLD
                                                           : r_rd_rgn;
    assign match    = owner_eq && (r_rel || (rd_canon == r_want));
    assign o_status.scan_end = r_rd_vld && (match || (r_rd_idx == LAST_IDX));

    // write-back select
    assign do_free  = r_rel && r_hit;
    assign do_claim = !r_rel && !r_hit && r_have_free;

    always_comb begin
        we     = 1'b0;
        waddr  = r_clr_idx;
        wowner = '0;
        wrgn   = osta_pkg::RGN_OVERWORLD;
        if (i_cmd.clr) begin
            we = 1'b1;
        end else if (i_cmd.fin && !r_reject && do_free) begin
            we    = 1'b1;
            waddr = r_hit_idx;
        end else if (i_cmd.fin && !r_reject && do_claim) begin
            we     = 1'b1;
            waddr  = r_free_idx;
            wowner = r_owner;
            wrgn   = r_want;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem_owner[waddr] <= wowner;
            r_mem_rgn[waddr]   <= wrgn;
        end
        if (rd_en) begin
            r_rd_owner <= r_mem_owner[r_raddr];
            r_rd_rgn   <= r_mem_rgn[r_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clr) begin
            r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld    <= 1'b0;
            r_issue_all <= 1'b0;
            r_raddr     <= '0;
        end else if (i_cmd.load) begin
            r_rd_vld    <= 1'b0;
            r_issue_all <= 1'b0;
            r_raddr     <= '0;
        end else begin
            r_rd_vld <= rd_en;
            if (rd_en) begin
                r_raddr <= r_raddr + 1'b1;
                if (r_raddr == LAST_IDX) begin
                    r_issue_all <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_idx <= r_raddr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_owner     <= in_owner;
            r_want      <= in_want;
            r_rel       <= (i_req_cmd == osta_pkg::CMD_RELEASE);
            r_reject    <= o_status.reject;
            r_hit       <= 1'b0;
            r_have_free <= 1'b0;
        end else if (eval) begin
            if (match) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_rd_idx;
            end
            if (!r_have_free && (r_rd_owner == '0)) begin
                r_have_free <= 1'b1;
                r_free_idx  <= r_rd_idx;
            end
        end
    end

    // result register
    assign hit_ext  = {{osta_pkg::SLOT_IDX_W{1'b0}}, r_hit_idx};
    assign free_ext = {{osta_pkg::SLOT_IDX_W{1'b0}}, r_free_idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_slot  <= osta_pkg::NO_SLOT;
            r_pres  <= 1'b0;
            r_claim <= 1'b0;
            r_relsd <= 1'b0;
            if (!r_reject) begin
                if (do_free) begin
                    r_slot  <= hit_ext[osta_pkg::SLOT_IDX_W-1:0];
                    r_relsd <= 1'b1;
                end else if (!r_rel && r_hit) begin
                    r_slot <= hit_ext[osta_pkg::SLOT_IDX_W-1:0];
                    r_pres <= 1'b1;
                end else if (do_claim) begin
                    r_slot  <= free_ext[osta_pkg::SLOT_IDX_W-1:0];
                    r_claim <= 1'b1;
                end
            end
        end
    end

    assign o_done         = r_done;
    assign o_slot_index   = r_slot;
    assign o_was_present  = r_pres;
    assign o_was_claimed  = r_claim;
    assign o_was_released = r_relsd;

endmodule

// File: hw/rtl/owner_slot_table_allocator_unit.sv
// ----------------------------------------------------------------------------
// owner_slot_table_allocator_unit
// Owner/region slot table with find-or-allocate and release requests.
//
//  channel   handshake              payload
//  request   start / busy           i_cmd, i_owner_id, i_region
//  result    o_done (one cycle)     o_slot_index, o_was_present,
//                                   o_was_claimed, o_was_released
//
// A request scans the slot memory one entry per cycle (single read port,
// registered read data); a scan stops at the first match. A request with
// owner zero, or a find request with an invalid region, skips the scan. After
// reset busy stays high while the table is cleared. The result strobe cannot
// be stalled; a new request may start in the cycle the result is shown.
// ----------------------------------------------------------------------------
module owner_slot_table_allocator_unit #(
    parameter int TABLE_DEPTH = 256,
    parameter int OWNER_BITS  = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   i_cmd,
    input  logic [osta_pkg::OWNER_IN_W-1:0]        i_owner_id,
    input  logic signed [1:0]                      i_region,
    output logic                                   o_done,
    output logic signed [osta_pkg::SLOT_IDX_W-1:0] o_slot_index,
    output logic                                   o_was_present,
    output logic                                   o_was_claimed,
    output logic                                   o_was_released
);

    osta_pkg::t_ctrl_cmd  ctrl_cmd;
    osta_pkg::t_dp_status dp_status;

    osta_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (dp_status),
        .o_cmd    (ctrl_cmd),
        .busy     (busy)
    );

    osta_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .OWNER_BITS  (OWNER_BITS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (ctrl_cmd),
        .o_status       (dp_status),
        .i_req_cmd      (i_cmd),
        .i_owner_id     (i_owner_id),
        .i_region       (i_region),
        .o_done         (o_done),
        .o_slot_index   (o_slot_index),
        .o_was_present  (o_was_present),
        .o_was_claimed  (o_was_claimed),
        .o_was_released (o_was_released)
    );

endmodule
